### hw/rtl/second_order_notch_filter_core_macros.svh
// Assertion macros used by the checker file of the notch filter.
`ifndef SECOND_ORDER_NOTCH_FILTER_CORE_MACROS_SVH
`define SECOND_ORDER_NOTCH_FILTER_CORE_MACROS_SVH

// Property checked on every rising clock edge, switched off while reset is low.
`define SONF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define SONF_ASSERT_NR(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/sonf_pkg.sv
package sonf_pkg;

	// Sample format and the guard bits kept on stored outputs.
	localparam int SAMPLE_W = 16;
	localparam int GUARD_W  = (SAMPLE_W <= 24) ? 8 : (32 - SAMPLE_W);
	localparam int Y_W      = SAMPLE_W + GUARD_W;

	// Coefficients are unsigned Q8.16; the multiplier's coefficient operand is
	// signed and wide enough for 2(a-8).
	localparam int COEF_W  = 24;
	localparam int DEN_W   = COEF_W + 1;
	localparam int CMUL_W  = COEF_W + 2;
	localparam int PROD_W  = CMUL_W + Y_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int GAIN_W  = Y_W + 6;
	localparam int DIV_CNT_W = $clog2(Y_W);

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BETA  = CFG_IDX_W'(1);
	localparam logic [COEF_W-1:0] ALPHA_RST = COEF_W'(268716);
	localparam logic [COEF_W-1:0] BETA_RST  = COEF_W'(133130);

	// Constants of the filter equation.
	localparam logic signed [CMUL_W-1:0] EIGHT_Q16 = CMUL_W'(524288);
	localparam logic signed [5:0] OUT_GAIN = 6'sd20;
	localparam int RND = (1 << GUARD_W) >> 1;

	// Saturation limits.
	localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
	localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};
	localparam logic [Y_W-1:0] Q_HALF = {1'b1, {(Y_W-1){1'b0}}};
	localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	// Multiply-accumulate step codes, one per term of the numerator.
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_X0 = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_X1 = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_X2 = STEP_W'(2);
	localparam logic [STEP_W-1:0] STEP_Y1 = STEP_W'(3);
	localparam logic [STEP_W-1:0] STEP_Y2 = STEP_W'(4);

endpackage

### hw/rtl/sonf_in_if.sv
interface sonf_in_if;
	logic valid;
	logic ready;
	logic signed [sonf_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

### hw/rtl/sonf_out_if.sv
interface sonf_out_if;
	logic valid;
	logic ready;
	logic signed [sonf_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

### hw/rtl/sonf_div.sv
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits in Y_W bits.
module sonf_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sonf_pkg::ACC_W-1:0]  dividend,
	input  logic [sonf_pkg::DEN_W-1:0]  divisor,
	output logic                        last,
	output logic [sonf_pkg::Y_W-1:0]    quotient
);

	logic                            busy_q;
	logic [sonf_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [sonf_pkg::DEN_W-1:0]      rem_q;
	logic [sonf_pkg::DEN_W-1:0]      den_q;
	logic [sonf_pkg::Y_W-1:0]        quo_q;
	logic [sonf_pkg::DEN_W:0]        shifted;
	logic [sonf_pkg::DEN_W:0]        trial;
	logic                            fits;

	assign shifted = {rem_q, quo_q[sonf_pkg::Y_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = !trial[sonf_pkg::DEN_W];
	assign last    = busy_q && (cnt_q == sonf_pkg::DIV_CNT_W'(sonf_pkg::Y_W - 1));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[sonf_pkg::Y_W +: sonf_pkg::DEN_W];
			quo_q <= dividend[sonf_pkg::Y_W-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[sonf_pkg::DEN_W-1:0] : shifted[sonf_pkg::DEN_W-1:0];
			quo_q <= {quo_q[sonf_pkg::Y_W-2:0], fits};
		end
	end

endmodule

### hw/rtl/second_order_notch_filter_core.sv
// Sequence: after an input transfer the sample takes five passes through the shared
// 26x24 multiplier, then the dividend preparation, the 24-step serial divider and the
// output scaling; the divide is skipped when the denominator is zero or the quotient
// overflows. A new sample is taken only once the previous result is in the output register.
// Reset: coefficient registers return to their reset values, the sample and output
// history clears to zero, and no result is pending.
module second_order_notch_filter_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sonf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sonf_pkg::COEF_W-1:0]     cfg_data,
	sonf_in_if.sink                         samples,
	sonf_out_if.source                      filtered
);

	// Sequencer states. A sample moves through the multiply-accumulate passes,
	// the dividend preparation, the divide and the final scaling in turn.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_PREP  = 3'd3;
	localparam logic [2:0] S_CHK   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [2:0] state_q;

	// Coefficient registers.
	logic [sonf_pkg::COEF_W-1:0] alpha_q;
	logic [sonf_pkg::COEF_W-1:0] beta_q;

	// Filter history: current and two previous inputs, two previous outputs.
	logic signed [sonf_pkg::SAMPLE_W-1:0] x0_q;
	logic signed [sonf_pkg::SAMPLE_W-1:0] x1_q;
	logic signed [sonf_pkg::SAMPLE_W-1:0] x2_q;
	logic signed [sonf_pkg::Y_W-1:0]      y1_q;
	logic signed [sonf_pkg::Y_W-1:0]      y2_q;

	// Per-sample derived coefficients, captured when the sample is taken.
	logic signed [sonf_pkg::CMUL_W-1:0] c1_q;
	logic signed [sonf_pkg::CMUL_W-1:0] c2_q;
	logic [sonf_pkg::DEN_W-1:0]         den_q;

	// Multiply-accumulate path.
	logic [sonf_pkg::STEP_W-1:0]        step_q;
	logic signed [sonf_pkg::CMUL_W-1:0] mul_coef;
	logic signed [sonf_pkg::Y_W-1:0]    mul_data;
	logic signed [sonf_pkg::PROD_W-1:0] mul_prod;
	logic signed [sonf_pkg::PROD_W-1:0] prod_s1;
	logic                               prod_v_s1;
	logic                               sub_s1;
	logic signed [sonf_pkg::ACC_W-1:0]  acc_q;
	logic signed [sonf_pkg::CMUL_W-1:0] alpha_ext;

	// Division and result shaping.
	logic                        neg_q;
	logic                        ovf_q;
	logic                        dzero_q;
	logic [sonf_pkg::ACC_W-1:0]  dvd_q;
	logic [sonf_pkg::ACC_W-1:0]  dvd_next;
	logic [sonf_pkg::DEN_W:0]    half_den;
	logic                        ovf_now;
	logic                        div_start;
	logic                        div_last;
	logic [sonf_pkg::Y_W-1:0]    div_quo;
	logic signed [sonf_pkg::Y_W-1:0] y_new;

	logic signed [sonf_pkg::GAIN_W-1:0]  gain;
	logic signed [sonf_pkg::GAIN_W-1:0]  gain_sh;
	logic signed [sonf_pkg::SAMPLE_W-1:0] out_next;
	logic                                out_valid_q;
	logic signed [sonf_pkg::SAMPLE_W-1:0] out_data_q;

	logic in_xfer;
	logic out_xfer;

	assign samples.ready       = (state_q == S_IDLE);
	assign in_xfer             = samples.valid && samples.ready;
	assign out_xfer            = out_valid_q && filtered.ready;
	assign filtered.valid      = out_valid_q;
	assign filtered.sample_out = out_data_q;

	assign alpha_ext = signed'(sonf_pkg::CMUL_W'(alpha_q));

	// Operand selection for the shared multiplier. Input samples enter the sum
	// scaled up by the guard bits so that they line up with stored outputs.
	always_comb begin
		case (step_q)
			sonf_pkg::STEP_X0: begin
				mul_coef = alpha_ext;
				mul_data = sonf_pkg::Y_W'(x0_q) <<< sonf_pkg::GUARD_W;
			end
			sonf_pkg::STEP_X1: begin
				mul_coef = c1_q;
				mul_data = sonf_pkg::Y_W'(x1_q) <<< sonf_pkg::GUARD_W;
			end
			sonf_pkg::STEP_X2: begin
				mul_coef = alpha_ext;
				mul_data = sonf_pkg::Y_W'(x2_q) <<< sonf_pkg::GUARD_W;
			end
			sonf_pkg::STEP_Y1: begin
				mul_coef = c1_q;
				mul_data = y1_q;
			end
			sonf_pkg::STEP_Y2: begin
				mul_coef = c2_q;
				mul_data = y2_q;
			end
			default: begin
				mul_coef = '0;
				mul_data = '0;
			end
		endcase
	end

	assign mul_prod = mul_coef * mul_data;

	// Rounded magnitude of the numerator as the dividend. For a negative sum,
	// -acc + den/2 equals ~acc + den/2 + 1, so a single wide add does it.
	assign half_den = {1'b0, den_q >> 1};
	assign dvd_next = (acc_q[sonf_pkg::ACC_W-1] ? ~acc_q : acc_q)
		+ sonf_pkg::ACC_W'(acc_q[sonf_pkg::ACC_W-1] ? half_den + 1'b1 : half_den);

	// The quotient fits Y_W bits exactly when the dividend is below den * 2^Y_W.
	assign ovf_now   = dvd_q >= (sonf_pkg::ACC_W'(den_q) << sonf_pkg::Y_W);
	assign div_start = (state_q == S_CHK) && !ovf_now && (den_q != '0);

	sonf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_q),
		.divisor  (den_q),
		.last     (div_last),
		.quotient (div_quo)
	);

	// Signed, saturated quotient. A zero denominator gives zero.
	always_comb begin
		if (dzero_q) begin
			y_new = '0;
		end else if (neg_q) begin
			y_new = (ovf_q || (div_quo > sonf_pkg::Q_HALF)) ? sonf_pkg::Y_MIN
				: signed'(~div_quo + 1'b1);
		end else begin
			y_new = (ovf_q || (div_quo > sonf_pkg::Y_W'(sonf_pkg::Y_MAX))) ? sonf_pkg::Y_MAX
				: signed'(div_quo);
		end
	end

	// Output gain: y * 20, rounded back to sample precision, saturated.
	assign gain    = sonf_pkg::GAIN_W'(y1_q) * sonf_pkg::OUT_GAIN
		+ sonf_pkg::GAIN_W'(sonf_pkg::RND);
	assign gain_sh = gain >>> sonf_pkg::GUARD_W;

	always_comb begin
		if (gain_sh > sonf_pkg::GAIN_W'(sonf_pkg::SMP_MAX)) begin
			out_next = sonf_pkg::SMP_MAX;
		end else if (gain_sh < sonf_pkg::GAIN_W'(sonf_pkg::SMP_MIN)) begin
			out_next = sonf_pkg::SMP_MIN;
		end else begin
			out_next = gain_sh[sonf_pkg::SAMPLE_W-1:0];
		end
	end

	// Sequencer, history and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			alpha_q     <= sonf_pkg::ALPHA_RST;
			beta_q      <= sonf_pkg::BETA_RST;
			x1_q        <= '0;
			x2_q        <= '0;
			y1_q        <= '0;
			y2_q        <= '0;
			step_q      <= sonf_pkg::STEP_X0;
			prod_v_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					sonf_pkg::CFG_ALPHA: alpha_q <= cfg_data;
					sonf_pkg::CFG_BETA:  beta_q  <= cfg_data;
					default: ;
				endcase
			end

			prod_v_s1 <= (state_q == S_MUL);

			// A new result may load in the same cycle as the old one transfers.
			if ((state_q == S_OUT) && (!out_valid_q || filtered.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						step_q  <= sonf_pkg::STEP_X0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 1'b1;
					if (step_q == sonf_pkg::STEP_Y2) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_PREP;
				S_PREP:  state_q <= S_CHK;
				S_CHK:   state_q <= div_start ? S_DIV : S_FIN;
				S_DIV: begin
					if (div_last) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					x2_q    <= x1_q;
					x1_q    <= x0_q;
					y2_q    <= y1_q;
					y1_q    <= y_new;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || filtered.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x0_q  <= samples.sample_in;
			c1_q  <= (alpha_ext - sonf_pkg::EIGHT_Q16) <<< 1;
			c2_q  <= alpha_ext - signed'(sonf_pkg::CMUL_W'(beta_q));
			den_q <= sonf_pkg::DEN_W'(alpha_q) + sonf_pkg::DEN_W'(beta_q);
			acc_q <= '0;
		end else if (prod_v_s1) begin
			acc_q <= sub_s1 ? acc_q - sonf_pkg::ACC_W'(prod_s1)
				: acc_q + sonf_pkg::ACC_W'(prod_s1);
		end

		prod_s1 <= mul_prod;
		sub_s1  <= (step_q == sonf_pkg::STEP_Y1) || (step_q == sonf_pkg::STEP_Y2);

		if (state_q == S_PREP) begin
			neg_q <= acc_q[sonf_pkg::ACC_W-1];
			dvd_q <= dvd_next;
		end

		if (state_q == S_CHK) begin
			ovf_q   <= ovf_now;
			dzero_q <= (den_q == '0);
		end

		if ((state_q == S_OUT) && (!out_valid_q || filtered.ready)) begin
			out_data_q <= out_next;
		end
	end

endmodule

### hw/rtl/sonf_checker.sv
`include "second_order_notch_filter_core_macros.svh"

module sonf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [sonf_pkg::SAMPLE_W-1:0] out_data
);

	`SONF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
	`SONF_ASSERT(a_out_stable, clk, arst_n, out_valid && !out_ready |=> $stable(out_data), "stalled result changed")
	`SONF_ASSERT(a_busy_after_take, clk, arst_n, in_valid && in_ready |=> !in_ready, "input taken while busy")
	`SONF_ASSERT(a_no_early_result, clk, arst_n, in_valid && in_ready |=> ##1 !$rose(out_valid), "result too early")
	`SONF_ASSERT_NR(a_reset_clear, clk, !arst_n |=> !out_valid, "result pending after reset")

endmodule

bind second_order_notch_filter_core sonf_checker u_sonf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.out_valid (filtered.valid),
	.out_ready (filtered.ready),
	.out_data  (filtered.sample_out)
);
